>>> rtl/core/frc16_pkg.sv
// Shared types, constants and the CRC byte update for the framed response checker.
package frc16_pkg;

    localparam int MAX_PAYLOAD = 64;
    localparam int FIFO_DEPTH  = 4;
    localparam int PTR_W       = $clog2(FIFO_DEPTH);
    localparam int CNT_W       = $clog2(FIFO_DEPTH + 1);

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // Fixed bytes of a frame: header (2), command, length (2), CRC (2), tail
    localparam logic [16:0] FRAME_FIXED = 17'd8;
    localparam logic [16:0] PAYLOAD_OFS = 17'd5;

    // Configuration register indexes
    localparam logic [1:0] CFG_HEADER_FIRST  = 2'd0;
    localparam logic [1:0] CFG_HEADER_SECOND = 2'd1;
    localparam logic [1:0] CFG_TAIL_VALUE    = 2'd2;

    // Status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_SHORT      = 3'd1;
    localparam logic [2:0] ST_BAD_HEADER = 3'd2;
    localparam logic [2:0] ST_TOO_LONG   = 3'd3;
    localparam logic [2:0] ST_INCOMPLETE = 3'd4;
    localparam logic [2:0] ST_BAD_TAIL   = 3'd5;
    localparam logic [2:0] ST_CRC_ERR    = 3'd6;

    typedef struct packed {
        logic       is_status;
        logic [7:0] payload_byte;
        logic [5:0] payload_index;
        logic [2:0] status_code;
        logic [6:0] payload_count;
    } result_t;

    // Up to two results per transfer; second is used only when cnt is 2
    typedef struct packed {
        logic [1:0] cnt;
        result_t    first;
        result_t    second;
    } push_t;

    typedef struct packed {
        logic [7:0] header_first;
        logic [7:0] header_second;
        logic [7:0] tail_value;
    } cfg_t;

    // Modbus CRC16, one byte, reflected, LSB first
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int k = 0; k < 8; k++) begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

>>> rtl/core/frc16_tracker.sv
// Frame state tracking: header/tail checks, length capture, CRC and result generation.
module frc16_tracker (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic [7:0]           rx_byte,
    input  logic                 end_of_transfer,
    input  frc16_pkg::cfg_t      cfg,
    output frc16_pkg::push_t     push
);

    logic [7:0]  pos_reg,   pos_next;
    logic        hdr_reg,   hdr_next;
    logic [15:0] len_reg,   len_next;
    logic [15:0] crc_reg,   crc_next;
    logic [15:0] rcrc_reg,  rcrc_next;
    logic        tail_reg,  tail_next;

    logic               len_ok;
    logic [16:0]        pos_ext;
    logic [16:0]        pay_end;
    logic               fwd;
    frc16_pkg::result_t pay_res;
    frc16_pkg::result_t st_res;
    logic [2:0]         code;

    assign pos_ext     = {9'd0, pos_reg};
    assign pay_end     = {1'b0, len_reg} + frc16_pkg::PAYLOAD_OFS;
    assign len_ok      = len_reg <= 16'(frc16_pkg::MAX_PAYLOAD);

    always_comb
    begin
        pos_next  = pos_reg;
        hdr_next  = hdr_reg;
        len_next  = len_reg;
        crc_next  = crc_reg;
        rcrc_next = rcrc_reg;
        tail_next = tail_reg;
        fwd       = 1'b0;

        pay_res               = '0;
        pay_res.payload_byte  = rx_byte;
        pay_res.payload_index = 6'(pos_reg - 8'd5);

        // Saturated counter: byte ignored
        if (pos_reg != 8'hFF)
        begin
            if (pos_reg == 8'd0)
                hdr_next = (rx_byte == cfg.header_first);
            else if (pos_reg == 8'd1)
                hdr_next = hdr_reg && (rx_byte == cfg.header_second);
            else if (pos_reg <= 8'd4)
            begin
                crc_next = frc16_pkg::crc16_byte(crc_reg, rx_byte);
                if (pos_reg == 8'd3)
                    len_next = {rx_byte, 8'h00};
                else if (pos_reg == 8'd4)
                    len_next = {len_reg[15:8], rx_byte};
            end
            else if (len_ok)
            begin
                if (pos_ext < pay_end)
                begin
                    crc_next = frc16_pkg::crc16_byte(crc_reg, rx_byte);
                    fwd      = hdr_reg;
                end
                else if (pos_ext == pay_end)
                    rcrc_next = {8'h00, rx_byte};
                else if (pos_ext == pay_end + 17'd1)
                    rcrc_next = {rx_byte, rcrc_reg[7:0]};
                else if (pos_ext == pay_end + 17'd2)
                    tail_next = (rx_byte == cfg.tail_value);
            end
            pos_next = pos_reg + 8'd1;
        end

        // Status from the values after this byte
        if ({9'd0, pos_next} < frc16_pkg::FRAME_FIXED)
            code = frc16_pkg::ST_SHORT;
        else if (!hdr_next)
            code = frc16_pkg::ST_BAD_HEADER;
        else if (len_next > 16'(frc16_pkg::MAX_PAYLOAD))
            code = frc16_pkg::ST_TOO_LONG;
        else if ({9'd0, pos_next} < {1'b0, len_next} + frc16_pkg::FRAME_FIXED)
            code = frc16_pkg::ST_INCOMPLETE;
        else if (!tail_next)
            code = frc16_pkg::ST_BAD_TAIL;
        else if (crc_next != rcrc_next)
            code = frc16_pkg::ST_CRC_ERR;
        else
            code = frc16_pkg::ST_OK;

        st_res               = '0;
        st_res.is_status     = 1'b1;
        st_res.status_code   = code;
        st_res.payload_count = (code == frc16_pkg::ST_OK) ? 7'(len_next) : 7'd0;

        push        = '0;
        push.first  = fwd ? pay_res : st_res;
        push.second = st_res;
        if (accept)
            push.cnt = 2'({1'b0, fwd} + {1'b0, end_of_transfer});

        if (accept && end_of_transfer)
        begin
            pos_next  = 8'd0;
            hdr_next  = 1'b1;
            len_next  = 16'd0;
            crc_next  = frc16_pkg::CRC_INIT;
            rcrc_next = 16'd0;
            tail_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= 8'd0;
            hdr_reg  <= 1'b1;
            len_reg  <= 16'd0;
            crc_reg  <= frc16_pkg::CRC_INIT;
            rcrc_reg <= 16'd0;
            tail_reg <= 1'b0;
        end
        else if (accept)
        begin
            pos_reg  <= pos_next;
            hdr_reg  <= hdr_next;
            len_reg  <= len_next;
            crc_reg  <= crc_next;
            rcrc_reg <= rcrc_next;
            tail_reg <= tail_next;
        end
    end

endmodule

>>> rtl/core/frc16_fifo.sv
// Small result queue: up to two pushes and one pop per cycle.
module frc16_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  frc16_pkg::push_t     push,
    output logic                 room,
    output logic                 out_valid,
    input  logic                 out_ready,
    output frc16_pkg::result_t   out_data
);

    frc16_pkg::result_t mem [frc16_pkg::FIFO_DEPTH];

    logic [frc16_pkg::PTR_W-1:0] wr_reg, wr_next;
    logic [frc16_pkg::PTR_W-1:0] rd_reg, rd_next;
    logic [frc16_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                        pop;

    assign out_valid = cnt_reg != '0;
    assign out_data  = mem[rd_reg];
    assign pop       = out_valid && out_ready;
    // Room for the worst case of two results from one byte
    assign room      = cnt_reg <= frc16_pkg::CNT_W'(frc16_pkg::FIFO_DEPTH - 2);

    always_comb
    begin
        wr_next  = wr_reg + frc16_pkg::PTR_W'(push.cnt);
        rd_next  = rd_reg + frc16_pkg::PTR_W'(pop);
        cnt_next = cnt_reg + frc16_pkg::CNT_W'(push.cnt) - frc16_pkg::CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.cnt != 2'd0)
            mem[wr_reg] <= push.first;
        if (push.cnt == 2'd2)
            mem[wr_reg + frc16_pkg::PTR_W'(1)] <= push.second;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

>>> rtl/core/framed_response_checker_crc16_unit.sv
// Top level of the framed response checker with Modbus CRC16.
//
// Input channel (in_valid/in_ready) takes one received byte per transfer,
// with end_of_transfer marking the final byte. The output channel
// (out_valid/out_ready) delivers results: a tentative payload byte
// (is_status 0) for each payload byte of a frame whose header matches and
// whose length is within range, and one status (is_status 1) on the final byte.
// Configuration writes (cfg_valid/cfg_ready, cfg_index, cfg_data) set the two
// header bytes and the tail byte; cfg_ready is always high.
// A result is registered in the result queue before it reaches the output.
// Throughput: one byte per cycle while in_ready is high; the frame state and
// CRC update complete in the accept cycle. A byte that yields both a payload
// result and a status delivers them one after the other, through the single
// output port of the four-entry result queue.
// in_ready is high while the queue has at least two free entries, so a stall
// on the output backs up into in_ready once three results are queued.
// Reset clears the frame state, sets the configuration registers to zero and
// empties the queue.
module framed_response_checker_crc16_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    input  logic       end_of_transfer,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       is_status,
    output logic [7:0] payload_byte,
    output logic [5:0] payload_index,
    output logic [2:0] status_code,
    output logic [6:0] payload_count,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data
);

    frc16_pkg::cfg_t    cfg_reg;
    frc16_pkg::push_t   push;
    frc16_pkg::result_t res;
    logic               accept;
    logic               room;

    assign cfg_ready = 1'b1;
    assign in_ready  = room;
    assign accept    = in_valid && room;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else if (cfg_valid)
        begin
            case (cfg_index)
                frc16_pkg::CFG_HEADER_FIRST:  cfg_reg.header_first  <= cfg_data;
                frc16_pkg::CFG_HEADER_SECOND: cfg_reg.header_second <= cfg_data;
                frc16_pkg::CFG_TAIL_VALUE:    cfg_reg.tail_value    <= cfg_data;
                default: ;
            endcase
        end
    end

    frc16_tracker u_tracker (
        .clk             (clk),
        .rst_n           (rst_n),
        .accept          (accept),
        .rx_byte         (rx_byte),
        .end_of_transfer (end_of_transfer),
        .cfg             (cfg_reg),
        .push            (push)
    );

    frc16_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (res)
    );

    assign is_status     = res.is_status;
    assign payload_byte  = res.payload_byte;
    assign payload_index = res.payload_index;
    assign status_code   = res.status_code;
    assign payload_count = res.payload_count;

endmodule

>>> rtl/core/frc16_checker.sv
// Port-level checks for the framed response checker, bound to the top level.
module frc16_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic       is_status,
    input  logic [7:0] payload_byte,
    input  logic [5:0] payload_index,
    input  logic [2:0] status_code,
    input  logic [6:0] payload_count
);

    // Stalled result holds its valid, is_status, payload_byte and status_code
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(is_status)
            && $stable(payload_byte) && $stable(status_code))
        else $error("result changed while stalled");

    a_status_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_status |-> payload_byte == 8'd0 && payload_index == 6'd0)
        else $error("status carries payload fields");

    a_payload_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !is_status |-> status_code == frc16_pkg::ST_OK
            && payload_count == 7'd0)
        else $error("payload result carries status fields");

    a_count_ok_only: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_status && status_code != frc16_pkg::ST_OK
            |-> payload_count == 7'd0)
        else $error("payload count on failed status");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_status |-> payload_count <= 7'(frc16_pkg::MAX_PAYLOAD)
            && status_code <= frc16_pkg::ST_CRC_ERR)
        else $error("status fields out of range");

endmodule

bind framed_response_checker_crc16_unit frc16_checker u_frc16_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .is_status     (is_status),
    .payload_byte  (payload_byte),
    .payload_index (payload_index),
    .status_code   (status_code),
    .payload_count (payload_count)
);
